// ----- rtl/core/atcc_pkg.sv -----
`default_nettype none

package atcc_pkg;

   localparam int MAX_WIDTH  = 32;
   localparam int MAX_HEIGHT = 1024;

   localparam int ROW_BITS   = MAX_WIDTH;
   localparam int PAD_BITS   = ROW_BITS + 2;
   localparam int COL_BITS   = 5;
   localparam int ROWC_BITS  = 10;
   localparam int GW_BITS    = 6;
   localparam int GH_BITS    = 11;
   localparam int CSR_BITS   = GH_BITS;
   localparam int KIND_BITS  = 3;
   localparam int TURN_BITS  = 2;

   // register indexes
   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   // tile kinds
   localparam logic [KIND_BITS-1:0] KIND_FULL  = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_FILL  = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_EDGE  = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_OUTER = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_INNER = 3'd4;

   typedef enum logic [2:0] {
      S_FILL,
      S_RDA,
      S_RDB,
      S_LD1,
      S_RUN1,
      S_LD2,
      S_SOLO,
      S_RUN2
   } atcc_state_type;

   typedef struct packed {
      logic                 start;
      logic [ROW_BITS-1:0]  above;
      logic [ROW_BITS-1:0]  cur;
      logic [ROW_BITS-1:0]  below;
      logic [ROWC_BITS-1:0] row;
      logic                 last;
      logic [GW_BITS-1:0]   width;
   } atcc_cmd_type;

   // corner pattern index is {TL, TR, BL, BR}
   function automatic logic [KIND_BITS-1:0] pattern_kind(input logic [3:0] idx);
      logic [KIND_BITS-1:0] k;
      unique case (idx)
         4'd0:                       k = KIND_FILL;
         4'd3, 4'd5, 4'd10, 4'd12:   k = KIND_EDGE;
         4'd7, 4'd11, 4'd13, 4'd14:  k = KIND_OUTER;
         4'd15:                      k = KIND_FULL;
         default:                    k = KIND_INNER;
      endcase
      return k;
   endfunction

   function automatic logic [TURN_BITS-1:0] pattern_turns(input logic [3:0] idx);
      logic [TURN_BITS-1:0] t;
      unique case (idx)
         4'd2, 4'd5, 4'd13:  t = 2'd1;
         4'd3, 4'd7, 4'd8:   t = 2'd2;
         4'd4, 4'd10, 4'd11: t = 2'd3;
         default:            t = 2'd0;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/autotile_corner_classifier.sv -----
// Channel  | Dir | Handshake              | Payload
// req_     | in  | req_valid / req_ready  | req_solid
// rsp_     | out | rsp_valid / rsp_ready  | cell_col, cell_row, tile_kind,
//          |     |                        | quarter_turns, run_last
// csr_     | in  | csr_wr_en              | csr_index, csr_wdata
//
// A cell that does not end a row goes straight into the accumulator, as does the first row
// end of a taller grid. Other row ends run the row memory reads (S_RDA, S_RDB) and the load
// S_LD1, then emit width results and return to intake; a single-row grid loads in S_SOLO
// instead. The final row end adds the load S_LD2 and a second run of width results. Stalls
// on rsp_ready stretch each run. Reset clears counters and control, not the row memory;
// req_ready is low from other row ends until their results are all in the output register.
`default_nettype none

module autotile_corner_classifier
   import atcc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_solid,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [COL_BITS-1:0]  rsp_cell_col,
   output logic      [ROWC_BITS-1:0] rsp_cell_row,
   output logic      [KIND_BITS-1:0] rsp_tile_kind,
   output logic      [TURN_BITS-1:0] rsp_quarter_turns,
   output logic                      rsp_run_last,
   input  wire logic                 csr_wr_en,
   input  wire logic                 csr_index,
   input  wire logic [CSR_BITS-1:0]  csr_wdata
);

   atcc_state_type       state_ff, state_in;
   logic [COL_BITS-1:0]  col_count_ff, col_count_in;
   logic [ROWC_BITS-1:0] row_count_ff, row_count_in;
   logic [ROW_BITS-1:0]  acc_ff, acc_in;
   logic                 ptr_ff, ptr_in;
   logic                 top_ones_ff, top_ones_in;
   logic [ROW_BITS-1:0]  above_ff, above_in;
   logic [ROW_BITS-1:0]  mid_ff, mid_in;
   logic [GW_BITS-1:0]   grid_width_ff;
   logic [GH_BITS-1:0]   grid_height_ff;

   logic [GW_BITS-1:0]   eff_width;
   logic [GH_BITS-1:0]   eff_height;
   logic                 req_fire;
   logic                 row_end;
   logic                 first_row;
   logic                 final_row;
   logic                 busy;

   logic                 mem_wr_en;
   logic [ROW_BITS-1:0]  mem_wr_data;
   logic                 mem_rd_addr;
   logic [ROW_BITS-1:0]  mem_rd_data;
   atcc_cmd_type         cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GW_BITS'(MAX_WIDTH);
         grid_height_ff <= GH_BITS'(32);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata[GW_BITS-1:0];
            CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata;
         endcase
      end
   end

   always_comb begin
      priority if (grid_width_ff == '0) begin
         eff_width = GW_BITS'(1);
      end else if (grid_width_ff > GW_BITS'(MAX_WIDTH)) begin
         eff_width = GW_BITS'(MAX_WIDTH);
      end else begin
         eff_width = grid_width_ff;
      end
      priority if (grid_height_ff == '0) begin
         eff_height = GH_BITS'(1);
      end else if (grid_height_ff > GH_BITS'(MAX_HEIGHT)) begin
         eff_height = GH_BITS'(MAX_HEIGHT);
      end else begin
         eff_height = grid_height_ff;
      end
   end

   assign req_ready = (state_ff == S_FILL);
   assign req_fire  = req_valid && req_ready;
   assign row_end   = ({1'b0, col_count_ff} + GW_BITS'(1)) >= eff_width;
   assign first_row = (row_count_ff == '0);
   assign final_row = ({1'b0, row_count_ff} + GH_BITS'(1)) >= eff_height;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_FILL: begin
            if (req_fire && row_end) begin
               priority if (!first_row) begin
                  state_in = S_RDA;
               end else if (final_row) begin
                  state_in = S_SOLO;
               end else begin
                  state_in = S_FILL;
               end
            end
         end
         S_RDA:  state_in = S_RDB;
         S_RDB:  state_in = S_LD1;
         S_LD1:  state_in = S_RUN1;
         S_RUN1: begin
            if (!busy) begin
               state_in = final_row ? S_LD2 : S_FILL;
            end
         end
         S_LD2:  state_in = S_RUN2;
         S_SOLO: state_in = S_RUN2;
         S_RUN2: begin
            if (!busy) begin
               state_in = S_FILL;
            end
         end
         default: state_in = S_FILL;
      endcase
   end

   // outputs and datapath
   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      acc_in       = acc_ff;
      ptr_in       = ptr_ff;
      top_ones_in  = top_ones_ff;
      above_in     = above_ff;
      mid_in       = mid_ff;
      mem_wr_en    = 1'b0;
      mem_wr_data  = acc_ff;
      mem_rd_addr  = (state_ff == S_RDA) ? !ptr_ff : ptr_ff;
      cmd          = '0;
      cmd.width    = eff_width;
      unique case (state_ff)
         S_FILL: begin
            if (req_fire) begin
               acc_in = ((col_count_ff == '0) ? '0 : acc_ff)
                        | (ROW_BITS'(req_solid) << col_count_ff);
               if (row_end) begin
                  col_count_in = '0;
                  if (first_row) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_data = acc_in;
                     ptr_in      = !ptr_ff;
                     top_ones_in = 1'b1;
                     if (!final_row) begin
                        row_count_in = row_count_ff + ROWC_BITS'(1);
                     end
                  end
               end else begin
                  col_count_in = col_count_ff + COL_BITS'(1);
               end
            end
         end
         S_RDA: begin
         end
         S_RDB: begin
            above_in = top_ones_ff ? '1 : mem_rd_data;
         end
         S_LD1: begin
            mid_in      = mem_rd_data;
            cmd.start   = 1'b1;
            cmd.above   = above_ff;
            cmd.cur     = mem_rd_data;
            cmd.below   = acc_ff;
            cmd.row     = row_count_ff - ROWC_BITS'(1);
            cmd.last    = !final_row;
            mem_wr_en   = 1'b1;
            ptr_in      = !ptr_ff;
            top_ones_in = 1'b0;
         end
         S_RUN1: begin
            if (!busy && !final_row) begin
               row_count_in = row_count_ff + ROWC_BITS'(1);
            end
         end
         S_LD2: begin
            cmd.start = 1'b1;
            cmd.above = mid_ff;
            cmd.cur   = acc_ff;
            cmd.below = '1;
            cmd.row   = row_count_ff;
            cmd.last  = 1'b1;
         end
         S_SOLO: begin
            cmd.start = 1'b1;
            cmd.above = '1;
            cmd.cur   = acc_ff;
            cmd.below = '1;
            cmd.row   = '0;
            cmd.last  = 1'b1;
         end
         S_RUN2: begin
            if (!busy) begin
               row_count_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         col_count_ff <= '0;
         row_count_ff <= '0;
         ptr_ff       <= 1'b0;
         top_ones_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         ptr_ff       <= ptr_in;
         top_ones_ff  <= top_ones_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      above_ff <= above_in;
      mid_ff   <= mid_in;
   end

   atcc_row_mem u_row_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (!ptr_ff),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   atcc_emitter u_emitter (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .busy              (busy),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cell_col      (rsp_cell_col),
      .rsp_cell_row      (rsp_cell_row),
      .rsp_tile_kind     (rsp_tile_kind),
      .rsp_quarter_turns (rsp_quarter_turns),
      .rsp_run_last      (rsp_run_last)
   );

endmodule

`default_nettype wire

// ----- rtl/core/atcc_row_mem.sv -----
`default_nettype none

module atcc_row_mem
   import atcc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic                wr_addr,
   input  wire logic [ROW_BITS-1:0] wr_data,
   input  wire logic                rd_addr,
   output logic      [ROW_BITS-1:0] rd_data
);

   logic [ROW_BITS-1:0] mem [2];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/core/atcc_emitter.sv -----
`default_nettype none

module atcc_emitter
   import atcc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire atcc_cmd_type         cmd,
   output logic                      busy,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [COL_BITS-1:0]  rsp_cell_col,
   output logic      [ROWC_BITS-1:0] rsp_cell_row,
   output logic      [KIND_BITS-1:0] rsp_tile_kind,
   output logic      [TURN_BITS-1:0] rsp_quarter_turns,
   output logic                      rsp_run_last
);

   logic                 busy_ff, busy_in;
   logic [PAD_BITS-1:0]  win_a_ff, win_a_in;
   logic [PAD_BITS-1:0]  win_c_ff, win_c_in;
   logic [PAD_BITS-1:0]  win_b_ff, win_b_in;
   logic [COL_BITS-1:0]  col_ff, col_in;
   logic [ROWC_BITS-1:0] row_ff, row_in;
   logic                 last_ff, last_in;

   logic                 valid_ff, valid_in;
   logic [COL_BITS-1:0]  o_col_ff, o_col_in;
   logic [ROWC_BITS-1:0] o_row_ff, o_row_in;
   logic [KIND_BITS-1:0] o_kind_ff, o_kind_in;
   logic [TURN_BITS-1:0] o_turn_ff, o_turn_in;
   logic                 o_last_ff, o_last_in;

   logic [ROW_BITS-1:0]  outside;
   logic [COL_BITS-1:0]  last_col;
   logic                 adv;
   logic                 fa, fb, fc, fd;
   logic [3:0]           idx;

   // columns at or past the width read as solid
   assign outside  = {ROW_BITS{1'b1}} << cmd.width;
   assign last_col = COL_BITS'(cmd.width - GW_BITS'(1));
   assign adv      = busy_ff && (!valid_ff || rsp_ready);

   assign fa  = win_a_ff[0] & win_a_ff[1] & win_c_ff[0];
   assign fb  = win_a_ff[1] & win_a_ff[2] & win_c_ff[2];
   assign fc  = win_c_ff[0] & win_b_ff[0] & win_b_ff[1];
   assign fd  = win_c_ff[2] & win_b_ff[1] & win_b_ff[2];
   assign idx = {fa, fb, fc, fd};

   always_comb begin
      busy_in   = busy_ff;
      win_a_in  = win_a_ff;
      win_c_in  = win_c_ff;
      win_b_in  = win_b_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      last_in   = last_ff;
      valid_in  = valid_ff && !rsp_ready;
      o_col_in  = o_col_ff;
      o_row_in  = o_row_ff;
      o_kind_in = o_kind_ff;
      o_turn_in = o_turn_ff;
      o_last_in = o_last_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         win_a_in = {1'b1, cmd.above | outside, 1'b1};
         win_c_in = {1'b1, cmd.cur | outside, 1'b1};
         win_b_in = {1'b1, cmd.below | outside, 1'b1};
         col_in   = '0;
         row_in   = cmd.row;
         last_in  = cmd.last;
      end else if (adv) begin
         valid_in  = 1'b1;
         o_col_in  = col_ff;
         o_row_in  = row_ff;
         o_kind_in = win_c_ff[1] ? pattern_kind(idx) : KIND_FILL;
         o_turn_in = win_c_ff[1] ? pattern_turns(idx) : '0;
         o_last_in = last_ff && (col_ff == last_col);
         win_a_in  = win_a_ff >> 1;
         win_c_in  = win_c_ff >> 1;
         win_b_in  = win_b_ff >> 1;
         col_in    = col_ff + COL_BITS'(1);
         if (col_ff == last_col) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_a_ff  <= win_a_in;
      win_c_ff  <= win_c_in;
      win_b_ff  <= win_b_in;
      col_ff    <= col_in;
      row_ff    <= row_in;
      last_ff   <= last_in;
      o_col_ff  <= o_col_in;
      o_row_ff  <= o_row_in;
      o_kind_ff <= o_kind_in;
      o_turn_ff <= o_turn_in;
      o_last_ff <= o_last_in;
   end

   assign busy              = busy_ff;
   assign rsp_valid         = valid_ff;
   assign rsp_cell_col      = o_col_ff;
   assign rsp_cell_row      = o_row_ff;
   assign rsp_tile_kind     = o_kind_ff;
   assign rsp_quarter_turns = o_turn_ff;
   assign rsp_run_last      = o_last_ff;

endmodule

`default_nettype wire

// ----- rtl/core/atcc_checker.sv -----
`default_nettype none

module atcc_checker
   import atcc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire logic                 req_solid,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire logic [COL_BITS-1:0]  rsp_cell_col,
   input  wire logic [ROWC_BITS-1:0] rsp_cell_row,
   input  wire logic [KIND_BITS-1:0] rsp_tile_kind,
   input  wire logic [TURN_BITS-1:0] rsp_quarter_turns,
   input  wire logic                 rsp_run_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_col)
         && $stable(rsp_cell_row) && $stable(rsp_tile_kind)
         && $stable(rsp_quarter_turns) && $stable(rsp_run_last))
      else $error("result changed while stalled");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tile_kind == KIND_FULL || rsp_tile_kind == KIND_FILL
         || rsp_tile_kind == KIND_EDGE || rsp_tile_kind == KIND_OUTER
         || rsp_tile_kind == KIND_INNER)
      else $error("tile kind out of range");

   a_plain_no_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_tile_kind == KIND_FULL || rsp_tile_kind == KIND_FILL)
         |-> rsp_quarter_turns == '0)
      else $error("full or fill tile with rotation");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_solid))
      else $error("request dropped or changed while stalled");

endmodule

bind autotile_corner_classifier atcc_checker u_atcc_checker (.*);

`default_nettype wire
